// ===== hw/rtl/lcabl_pkg.sv =====
// shared sizes, codes and types for the lowest common ancestor unit
package lcabl_pkg;

  localparam int MAX_NODES = 65536;
  localparam int LEVELS    = 16;

  localparam int NODE_W    = 16;
  localparam int NODE_CLOG = $clog2(MAX_NODES);
  localparam int NODE_AW   = (NODE_CLOG > NODE_W) ? NODE_W : NODE_CLOG;
  localparam int LVL_W     = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int JT_AW     = NODE_AW + LVL_W;

  localparam logic [LVL_W-1:0] LVL_MAX = LVL_W'(LEVELS - 1);

  typedef logic [NODE_W-1:0] node_t;
  typedef logic [LVL_W-1:0]  lvl_t;
  typedef logic [JT_AW-1:0]  jt_addr_t;

  localparam logic OP_ADD   = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef enum logic [8:0] {
    S_IDLE    = 9'b000000001,
    S_ADD_DEP = 9'b000000010,
    S_ADD_JT  = 9'b000000100,
    S_Q_DEP   = 9'b000001000,
    S_L1_JT   = 9'b000010000,
    S_L1_DP   = 9'b000100000,
    S_L2_JT   = 9'b001000000,
    S_Q_FIN   = 9'b010000000,
    S_Q_OUT   = 9'b100000000
  } state_t;

endpackage

// ===== hw/rtl/lca_binary_lifting_table_unit.sv =====
// lowest common ancestor unit: ancestor table, depth memory and lifting sequencer
//
// A tree is kept with node 0 as root. Input items carry in_operation, in_node_a and
// in_node_b. An add item (operation 0) hangs child node_b under parent node_a and gives
// no result; a query item (operation 1) gives one result, out_ancestor, the lowest
// common ancestor of node_a and node_b. Both channels use valid/stall: an item moves on
// a rising edge with valid high and stall low.
// One item is worked on at a time; in_stall is high from acceptance until the sequencer
// is done. The ancestor table and the depth memory are read through registers, and each
// lifting step waits on the previous read:
//   add:   one table entry written per cycle, level 0 (with the depth) first, then upward
//   query: the depths, then for each first-pass step a table read and a depth read,
//          for each second-pass step a read of both rows, then S_Q_FIN and S_Q_OUT
// The result waits in an output register; the next item is taken while it waits, and a
// query that finishes while out_stall holds the old result waits for the slot.
// Reset clears the sequencer and the output valid. The root's row and depth read as zero
// without a clearing pass; the memories need no initialization if the user queries a
// node only after it has been added, which the block itself does not enforce.
module lca_binary_lifting_table_unit
  import lcabl_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              in_operation,
  input  logic [NODE_W-1:0] in_node_a,
  input  logic [NODE_W-1:0] in_node_b,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [NODE_W-1:0] out_ancestor
);

  function automatic jt_addr_t jt_addr(input node_t node, input lvl_t lvl);
    jt_addr = {node[NODE_AW-1:0], lvl};
  endfunction

  // memories
  node_t jt_mem [0:(2**JT_AW)-1];
  node_t dp_mem [0:(2**NODE_AW)-1];

  state_t state_r, state_nxt;
  node_t  a_r, a_nxt, b_r, b_nxt;
  node_t  da_r, da_nxt, db_r, db_nxt;
  node_t  p_r, p_nxt, res_r, res_nxt;
  lvl_t   k_r, k_nxt;
  logic   out_valid_r, out_load;
  node_t  out_ancestor_r;

  jt_addr_t jt_ra0, jt_ra1, jt_wa;
  node_t    jt_wd;
  logic     jt_we;
  node_t    jt_q0_r, jt_q1_r, jt_fwd_d_r;
  logic     jt_z0_r, jt_z1_r, jt_fwd_r;
  node_t    jt_d0, jt_d1;

  node_t    dp_ra0, dp_ra1, dp_wa, dp_wd;
  logic     dp_we;
  node_t    dp_q0_r, dp_q1_r;
  logic     dp_z0_r, dp_z1_r;
  node_t    dp_d0, dp_d1;

  logic in_acc, a_ok, b_ok;
  logic enter_p1, enter_p2;

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign a_ok     = 32'(in_node_a) < MAX_NODES;
  assign b_ok     = 32'(in_node_b) < MAX_NODES;

  // ancestor table, read-before-write, with forwarding on port 0
  always_ff @(posedge clk) begin
    if (jt_we) begin
      jt_mem[jt_wa] <= jt_wd;
    end
    jt_q0_r    <= jt_mem[jt_ra0];
    jt_q1_r    <= jt_mem[jt_ra1];
    jt_z0_r    <= (jt_ra0[JT_AW-1:LVL_W] == '0);
    jt_z1_r    <= (jt_ra1[JT_AW-1:LVL_W] == '0);
    jt_fwd_r   <= jt_we && (jt_wa == jt_ra0);
    jt_fwd_d_r <= jt_wd;
  end

  // root row always reads zero
  assign jt_d0 = jt_z0_r ? '0 : (jt_fwd_r ? jt_fwd_d_r : jt_q0_r);
  assign jt_d1 = jt_z1_r ? '0 : jt_q1_r;

  always_ff @(posedge clk) begin
    if (dp_we) begin
      dp_mem[dp_wa[NODE_AW-1:0]] <= dp_wd;
    end
    dp_q0_r <= dp_mem[dp_ra0[NODE_AW-1:0]];
    dp_q1_r <= dp_mem[dp_ra1[NODE_AW-1:0]];
    dp_z0_r <= (dp_ra0 == '0);
    dp_z1_r <= (dp_ra1 == '0);
  end

  assign dp_d0 = dp_z0_r ? '0 : dp_q0_r;
  assign dp_d1 = dp_z1_r ? '0 : dp_q1_r;

  always_comb begin
    state_nxt = state_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    da_nxt    = da_r;
    db_nxt    = db_r;
    p_nxt     = p_r;
    res_nxt   = res_r;
    k_nxt     = k_r;
    jt_ra0    = jt_addr(a_r, k_r);
    jt_ra1    = jt_addr(b_r, k_r);
    jt_we     = 1'b0;
    jt_wa     = jt_addr(b_r, k_r);
    jt_wd     = jt_d0;
    dp_ra0    = a_r;
    dp_ra1    = b_r;
    dp_we     = 1'b0;
    dp_wa     = b_r;
    dp_wd     = (dp_d0 == '1) ? dp_d0 : dp_d0 + 1'b1;
    out_load  = 1'b0;
    enter_p1  = 1'b0;
    enter_p2  = 1'b0;

    case (state_r)
      S_IDLE: begin
        dp_ra0 = in_node_a;
        dp_ra1 = in_node_b;
        if (in_acc) begin
          a_nxt = in_node_a;
          b_nxt = in_node_b;
          if (in_operation == OP_ADD) begin
            if (a_ok && b_ok && in_node_b != '0) begin
              state_nxt = S_ADD_DEP;
            end
          end else if (a_ok && b_ok) begin
            state_nxt = S_Q_DEP;
          end else begin
            res_nxt   = '0;
            state_nxt = S_Q_OUT;
          end
        end
      end
      S_ADD_DEP: begin
        // a_r is the parent, b_r the child
        dp_we  = 1'b1;
        jt_we  = 1'b1;
        jt_wa  = jt_addr(b_r, '0);
        jt_wd  = a_r;
        jt_ra0 = jt_addr(a_r, '0);
        k_nxt  = lvl_t'(1);
        if (LEVELS == 1) begin
          state_nxt = S_IDLE;
        end else begin
          state_nxt = S_ADD_JT;
        end
      end
      S_ADD_JT: begin
        // jt_d0 is the ancestor at level k
        jt_we  = 1'b1;
        jt_wa  = jt_addr(b_r, k_r);
        jt_wd  = jt_d0;
        jt_ra0 = jt_addr(jt_d0, k_r);
        k_nxt  = k_r + 1'b1;
        if (k_r == LVL_MAX) begin
          state_nxt = S_IDLE;
        end
      end
      S_Q_DEP: begin
        if (dp_d0 < dp_d1) begin
          a_nxt  = b_r;
          b_nxt  = a_r;
          da_nxt = dp_d1;
          db_nxt = dp_d0;
        end else begin
          da_nxt = dp_d0;
          db_nxt = dp_d1;
        end
        enter_p1 = 1'b1;
      end
      S_L1_JT: begin
        p_nxt     = jt_d0;
        dp_ra0    = jt_d0;
        state_nxt = S_L1_DP;
      end
      S_L1_DP: begin
        if (dp_d0 >= db_r) begin
          a_nxt  = p_r;
          da_nxt = dp_d0;
        end
        if (k_r == '0) begin
          enter_p2 = 1'b1;
        end else begin
          k_nxt = k_r - 1'b1;
          if (da_nxt > db_r) begin
            jt_ra0    = jt_addr(a_nxt, k_r - 1'b1);
            state_nxt = S_L1_JT;
          end else begin
            enter_p2 = 1'b1;
          end
        end
      end
      S_L2_JT: begin
        if (jt_d0 != jt_d1) begin
          a_nxt = jt_d0;
          b_nxt = jt_d1;
        end
        if (a_nxt == b_nxt) begin
          res_nxt   = b_nxt;
          state_nxt = S_Q_OUT;
        end else if (k_r == '0) begin
          jt_ra0    = jt_addr(a_nxt, '0);
          state_nxt = S_Q_FIN;
        end else begin
          k_nxt  = k_r - 1'b1;
          jt_ra0 = jt_addr(a_nxt, k_r - 1'b1);
          jt_ra1 = jt_addr(b_nxt, k_r - 1'b1);
        end
      end
      S_Q_FIN: begin
        res_nxt   = jt_d0;
        state_nxt = S_Q_OUT;
      end
      S_Q_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // first pass: lift the deeper node
    if (enter_p1) begin
      k_nxt = LVL_MAX;
      if (da_nxt > db_nxt) begin
        jt_ra0    = jt_addr(a_nxt, LVL_MAX);
        state_nxt = S_L1_JT;
      end else begin
        enter_p2 = 1'b1;
      end
    end

    // second pass: lift both while ancestors differ
    if (enter_p2) begin
      k_nxt = LVL_MAX;
      if (a_nxt != b_nxt) begin
        jt_ra0    = jt_addr(a_nxt, LVL_MAX);
        jt_ra1    = jt_addr(b_nxt, LVL_MAX);
        state_nxt = S_L2_JT;
      end else begin
        res_nxt   = b_nxt;
        state_nxt = S_Q_OUT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    a_r   <= a_nxt;
    b_r   <= b_nxt;
    da_r  <= da_nxt;
    db_r  <= db_nxt;
    p_r   <= p_nxt;
    res_r <= res_nxt;
    k_r   <= k_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_ancestor_r <= res_r;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_ancestor = out_ancestor_r;

  // a result only appears from the output state
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_Q_OUT))
    else $error("result appeared outside the output state");

  // the root row is never overwritten
  a_root_row: assert property (@(posedge clk) disable iff (!rst_n)
    jt_we |-> (jt_wa[JT_AW-1:LVL_W] != '0))
    else $error("write into the root row of the ancestor table");

  // while lifting the deeper node it never goes above the other
  a_lift_depth: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_L1_JT || state_r == S_L1_DP) |-> (da_r >= db_r))
    else $error("first lifting pass overshot the target depth");

endmodule
